// File: hw/rtl/fpss_pkg.sv
// Shared types, register map and constants for the fixed-point sprite scaler.
package fpss_pkg;

  // Default width of the internal address arithmetic
  localparam int unsigned ADDRESS_BITS_DEF = 24;

  // Width of the address fields on the result channel
  localparam int unsigned ADDR_FIELD_BITS = 24;

  // Configuration port
  localparam int unsigned CFG_ADDR_BITS = 5;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned REG_IDX_BITS  = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_X_STEP        = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_Y_STEP        = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_SPRITE_WIDTH  = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_SPRITE_HEIGHT = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_SRC_PITCH     = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_DEST_PITCH    = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_COLOR_KEY     = 3'd6;

  // Reset values of the registers
  localparam logic [15:0] X_STEP_RST        = 16'd256;
  localparam logic [15:0] Y_STEP_RST        = 16'd256;
  localparam logic [7:0]  SPRITE_WIDTH_RST  = 8'd1;
  localparam logic [7:0]  SPRITE_HEIGHT_RST = 8'd1;
  localparam logic [15:0] SRC_PITCH_RST     = 16'd0;
  localparam logic [15:0] DEST_PITCH_RST    = 16'd0;
  localparam logic        COLOR_KEY_RST     = 1'b0;

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef struct packed {
    logic [15:0] x_step;
    logic [15:0] y_step;
    logic [7:0]  sprite_width;
    logic [7:0]  sprite_height;
    logic [15:0] source_row_pitch;
    logic [15:0] dest_row_pitch;
    logic        color_key_mode;
  } cfg_t;

  typedef struct packed {
    logic        operation;
    logic [11:0] start_x;
    logic [11:0] start_y;
    logic [15:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic        write_enable;
    logic [23:0] dest_address;
    logic [15:0] write_data;
    logic [23:0] source_address;
    logic        fetch_valid;
    logic        frame_done;
  } out_item_t;

endpackage

// File: hw/rtl/fpss_cfg.sv
// Configuration register bank behind the APB-style port.
module fpss_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [fpss_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [fpss_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [fpss_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready,
  output fpss_pkg::cfg_t                       cfg
);
  import fpss_pkg::*;

  cfg_t                    cfg_r;
  cfg_t                    cfg_nxt;
  logic [REG_IDX_BITS-1:0] reg_idx;
  logic                    wr_en;

  // Word-aligned decode: byte lanes within a word are ignored
  assign reg_idx = paddr[CFG_ADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_X_STEP:        cfg_nxt.x_step           = pwdata[15:0];
        REG_Y_STEP:        cfg_nxt.y_step           = pwdata[15:0];
        REG_SPRITE_WIDTH:  cfg_nxt.sprite_width     = pwdata[7:0];
        REG_SPRITE_HEIGHT: cfg_nxt.sprite_height    = pwdata[7:0];
        REG_SRC_PITCH:     cfg_nxt.source_row_pitch = pwdata[15:0];
        REG_DEST_PITCH:    cfg_nxt.dest_row_pitch   = pwdata[15:0];
        REG_COLOR_KEY:     cfg_nxt.color_key_mode   = pwdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_X_STEP:        prdata = CFG_DATA_BITS'(cfg_r.x_step);
      REG_Y_STEP:        prdata = CFG_DATA_BITS'(cfg_r.y_step);
      REG_SPRITE_WIDTH:  prdata = CFG_DATA_BITS'(cfg_r.sprite_width);
      REG_SPRITE_HEIGHT: prdata = CFG_DATA_BITS'(cfg_r.sprite_height);
      REG_SRC_PITCH:     prdata = CFG_DATA_BITS'(cfg_r.source_row_pitch);
      REG_DEST_PITCH:    prdata = CFG_DATA_BITS'(cfg_r.dest_row_pitch);
      REG_COLOR_KEY:     prdata = CFG_DATA_BITS'(cfg_r.color_key_mode);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_step           <= X_STEP_RST;
      cfg_r.y_step           <= Y_STEP_RST;
      cfg_r.sprite_width     <= SPRITE_WIDTH_RST;
      cfg_r.sprite_height    <= SPRITE_HEIGHT_RST;
      cfg_r.source_row_pitch <= SRC_PITCH_RST;
      cfg_r.dest_row_pitch   <= DEST_PITCH_RST;
      cfg_r.color_key_mode   <= COLOR_KEY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: hw/rtl/fpss_engine.sv
// Accumulator state, per-item step logic and the result register.
module fpss_engine #(
  parameter int unsigned ADDRESS_BITS = fpss_pkg::ADDRESS_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fpss_pkg::cfg_t       cfg,
  input  logic                 item_valid,
  input  fpss_pkg::in_item_t   item,
  output logic                 item_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fpss_pkg::out_item_t  out_data
);
  import fpss_pkg::*;

  logic [15:0]             x_acc_r, x_acc_nxt;
  logic [15:0]             y_acc_r, y_acc_nxt;
  logic [ADDRESS_BITS-1:0] row_start_r, row_start_nxt;
  logic [ADDRESS_BITS-1:0] dest_ptr_r, dest_ptr_nxt;
  logic                    active_r, active_nxt;
  logic                    out_valid_r;
  out_item_t               out_data_r, result;
  logic                    adv;

  logic [15:0]             x_sum, y_sum;
  logic                    row_end;
  logic [27:0]             origin_prod;
  logic [28:0]             origin_sum;
  logic [7:0]              src_row, src_col;
  logic [23:0]             src_prod;
  logic [24:0]             src_sum;
  logic [ADDRESS_BITS-1:0] src_addr;
  logic [ADDRESS_BITS-1:0] row_next;

  // Take an item whenever the result register is empty or being drained
  assign item_ready = !out_valid_r || out_ready;
  assign adv        = item_valid && item_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // Destination origin: pitch * y + x
  assign origin_prod = 28'(cfg.dest_row_pitch) * 28'(item.start_y);
  assign origin_sum  = 29'(origin_prod) + 29'(item.start_x);

  assign x_sum    = x_acc_r + cfg.x_step;
  assign y_sum    = y_acc_r + cfg.y_step;
  assign row_end  = x_sum[15:8] >= cfg.sprite_width;
  assign row_next = row_start_r + ADDRESS_BITS'(cfg.dest_row_pitch);

  // Next fetch from the advanced accumulators
  assign src_row  = row_end ? y_sum[15:8] : y_acc_r[15:8];
  assign src_col  = row_end ? 8'd0 : x_sum[15:8];
  assign src_prod = 24'(src_row) * 24'(cfg.source_row_pitch);
  assign src_sum  = 25'(src_prod) + 25'(src_col);
  assign src_addr = ADDRESS_BITS'(src_sum);

  always_comb begin
    x_acc_nxt     = x_acc_r;
    y_acc_nxt     = y_acc_r;
    row_start_nxt = row_start_r;
    dest_ptr_nxt  = dest_ptr_r;
    active_nxt    = active_r;
    result        = '0;
    if (item.operation == OP_START) begin
      row_start_nxt      = ADDRESS_BITS'(origin_sum);
      dest_ptr_nxt       = ADDRESS_BITS'(origin_sum);
      x_acc_nxt          = '0;
      y_acc_nxt          = '0;
      active_nxt         = 1'b1;
      result.fetch_valid = 1'b1;
    end else if (active_r) begin
      result.write_enable = !(cfg.color_key_mode && (item.pixel_value == '0));
      result.dest_address = ADDR_FIELD_BITS'(dest_ptr_r);
      result.write_data   = item.pixel_value;
      if (!row_end) begin
        x_acc_nxt             = x_sum;
        dest_ptr_nxt          = dest_ptr_r + ADDRESS_BITS'(1);
        result.source_address = ADDR_FIELD_BITS'(src_addr);
        result.fetch_valid    = 1'b1;
      end else begin
        row_start_nxt = row_next;
        dest_ptr_nxt  = row_next;
        y_acc_nxt     = y_sum;
        x_acc_nxt     = '0;
        if (y_sum[15:8] < cfg.sprite_height) begin
          result.source_address = ADDR_FIELD_BITS'(src_addr);
          result.fetch_valid    = 1'b1;
        end else begin
          result.frame_done = 1'b1;
          active_nxt        = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_acc_r     <= '0;
      y_acc_r     <= '0;
      row_start_r <= '0;
      dest_ptr_r  <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        x_acc_r     <= x_acc_nxt;
        y_acc_r     <= y_acc_nxt;
        row_start_r <= row_start_nxt;
        dest_ptr_r  <= dest_ptr_nxt;
        active_r    <= active_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= result;
    end
  end

endmodule

// File: hw/rtl/fixed_point_sprite_scaler.sv
// Top level of the fixed-point sprite scaler: input register, engine and register bank.
//
// Nearest-neighbour sprite scaler stepping through the source with unsigned 8.8
// accumulators. Send a start beat (operation 0) with the destination origin; the
// result carries the first source fetch address. Send each fetched source word as
// a pixel beat (operation 1); its result carries the destination write, the next
// source fetch and, on the last pixel of the last row, frame_done. Every input
// beat gives exactly one result beat. Throughput is one beat per clock while
// neither side stalls. The input register captures the beat at the accepting
// edge; when the engine takes it from there, the step logic updates the
// accumulators and fills the result register, which then shows the result. The
// rate is set by the accumulator update, which each beat needs before the next
// one can be stepped. Both sides can stall; an input beat is still taken while a
// result waits to be collected, as long as the input register is empty. Write
// the registers through the APB-style port (register i at byte address 4*i) only
// while no beat is in flight. ADDRESS_BITS sets the width of the address
// arithmetic; addresses wrap at that width and are then shown on the 24-bit
// result fields.
module fixed_point_sprite_scaler #(
  parameter int unsigned ADDRESS_BITS = fpss_pkg::ADDRESS_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  fpss_pkg::in_item_t                   in_data,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output fpss_pkg::out_item_t                  out_data,
  // Configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [fpss_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [fpss_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [fpss_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);
  import fpss_pkg::*;

  cfg_t     cfg;
  logic     in_valid_r;
  in_item_t in_item_r;
  logic     eng_ready;
  logic     in_take;

  // The input register refills in the same cycle the engine drains it
  assign in_ready = !in_valid_r || eng_ready;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (eng_ready) begin
        // drop the held beat once the engine has taken it
        in_valid_r <= 1'b0;
      end
    end
  end

  // Hold the payload until the engine takes it
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
  end

  fpss_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fpss_engine #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (in_valid_r),
    .item       (in_item_r),
    .item_ready (eng_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
